@@ hw/rtl/pchg_pkg.sv @@
`default_nettype none

package pchg_pkg;

    localparam int COORD_W    = 24;
    localparam int EDGE_W     = 16;
    localparam int USE_W      = 9;
    localparam int CELL_IDX_W = 8;
    localparam int GREY_W     = 8;
    localparam int OUT_CNT_W  = 16;
    localparam int SUM_W      = 40;
    localparam int NUM_W      = SUM_W + GREY_W;
    localparam int QUO_W      = 24;
    localparam int PAD_W      = QUO_W - GREY_W;
    localparam int STEP_W     = 5;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_Z     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_SPAN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CELL_EDGE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLS_IN_USE = 3'd6;

    localparam logic [STEP_W-1:0] COORD_STEPS = 5'd24;
    localparam logic [STEP_W-1:0] GREY_STEPS  = 5'd8;

    localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_z;
        logic [CELL_IDX_W-1:0] query_row;
        logic [CELL_IDX_W-1:0] query_col;
    } item_t;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_row;
        logic [CELL_IDX_W-1:0] cell_col;
        logic                  in_grid;
        logic [GREY_W-1:0]     grey_level;
        logic [OUT_CNT_W-1:0]  point_count;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] floor_z;
        logic [COORD_W-1:0] height_span;
        logic [EDGE_W-1:0]  cell_edge;
        logic [USE_W-1:0]   rows_in_use;
        logic [USE_W-1:0]   cols_in_use;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_x:    24'd0,
        origin_y:    24'd0,
        floor_z:     24'd0,
        height_span: 24'd1000,
        cell_edge:   16'd50,
        rows_in_use: 9'd256,
        cols_in_use: 9'd256
    };

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_XGO,
        S_XWAIT,
        S_YWAIT,
        S_QCHK,
        S_READ,
        S_MODIFY,
        S_SCALE,
        S_GREY,
        S_GWAIT,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/point_cloud_height_grid_top.sv @@
// Height-map grid: each ADD transaction bins a point (x, y, z in mm) into a square cell by floor
// division against the configured origin and cell edge, and adds its clamped height to that
// cell's sum and count; READ returns a cell's count and mean height scaled to a 0..255 grey
// level; CLEAR empties the grid. Per-cell sum and count live in one RAM of
// GRID_ROWS*GRID_COLS entries, read-modify-written one transaction at a time. One transaction
// is in flight at a time: an ADD is paced by the shared bit-serial divider (24 steps for the
// column, 24 for the row, 8 for the grey level) plus the RAM read and update. CLEAR sweeps the
// RAM one entry per cycle. After reset the same sweep runs with item_stall held high; register
// writes are taken throughout. A finished result waits in an output register, so the next
// transaction is accepted while the previous result is still stalled.
`default_nettype none

module point_cloud_height_grid_top
    import pchg_pkg::*;
#(
    parameter int GRID_ROWS  = 256,
    parameter int GRID_COLS  = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  wire  item_t           item,
    output logic                  result_valid,
    input  wire                   result_stall,
    output result_t               result,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CELLS   = GRID_ROWS * GRID_COLS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ENTRY_W = SUM_W + COUNT_BITS;
    localparam int DEN_W   = COUNT_BITS + COORD_W;
    localparam int CMP_W   = (DEN_W + GREY_W > NUM_W) ? DEN_W + GREY_W : NUM_W;
    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [CELL_AW-1:0] clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    item_t              item_reg;
    logic [QUO_W-1:0]   row_reg, col_reg, col_q_reg;
    logic               col_ok_reg, ing_reg;
    logic [CELL_AW-1:0] addr_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [DEN_W-1:0]   prod_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [GREY_W-1:0]  grey_reg;
    logic [COORD_W-1:0] hgt_reg;

    logic               accept;
    logic               slot_free;
    logic               clr_last;
    logic signed [COORD_W:0] dx, dy, dz;
    logic [EDGE_W-1:0]  edge_eff;
    logic [COORD_W-1:0] span_eff;
    logic [QUO_W-1:0]   row_lim, col_lim;
    logic [COORD_W-1:0] hgt;
    logic               col_ok, row_ok, query_ok;
    logic [QUO_W-1:0]   q_row, q_col;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [COUNT_BITS-1:0] rd_cnt, wr_cnt, ent_cnt;
    logic [SUM_W-1:0]   rd_sum, ent_sum, new_sum;
    logic [SUM_W:0]     sum_add;
    logic [ENTRY_W-1:0] upd_entry;
    logic               is_add;
    logic               cnt_zero, grey_sat;

    div_cmd_t           div_cmd;
    logic [DEN_W-1:0]   div_rem, div_den;
    logic [QUO_W-1:0]   div_num, div_quo;
    logic               div_done;

    pchg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pchg_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo)
    );

    pchg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    // Coordinates and limits
    always_comb
    begin
        dx = $signed({item_reg.point_x[COORD_W-1], item_reg.point_x})
           - $signed({cfg.origin_x[COORD_W-1], cfg.origin_x});
        dy = $signed({item_reg.point_y[COORD_W-1], item_reg.point_y})
           - $signed({cfg.origin_y[COORD_W-1], cfg.origin_y});
        dz = $signed({item_reg.point_z[COORD_W-1], item_reg.point_z})
           - $signed({cfg.floor_z[COORD_W-1], cfg.floor_z});

        edge_eff = (cfg.cell_edge == '0) ? EDGE_W'(1) : cfg.cell_edge;
        span_eff = (cfg.height_span == '0) ? COORD_W'(1) : cfg.height_span;

        row_lim = (QUO_W'(cfg.rows_in_use) > QUO_W'(GRID_ROWS))
                ? QUO_W'(GRID_ROWS) : QUO_W'(cfg.rows_in_use);
        col_lim = (QUO_W'(cfg.cols_in_use) > QUO_W'(GRID_COLS))
                ? QUO_W'(GRID_COLS) : QUO_W'(cfg.cols_in_use);

        // clamp height to 0..span
        if (dz[COORD_W])
        begin
            hgt = '0;
        end
        else if (dz[COORD_W-1:0] > span_eff)
        begin
            hgt = span_eff;
        end
        else
        begin
            hgt = dz[COORD_W-1:0];
        end

        col_ok   = !dx[COORD_W] && (div_quo < col_lim);
        row_ok   = !dy[COORD_W] && (div_quo < row_lim);
        q_row    = QUO_W'(item_reg.query_row);
        q_col    = QUO_W'(item_reg.query_col);
        query_ok = (q_row < row_lim) && (q_col < col_lim);
    end

    // Cell update
    always_comb
    begin
        is_add  = (item_reg.mode == MODE_ADD);
        rd_cnt  = ram_rdata[COUNT_BITS-1:0];
        rd_sum  = ram_rdata[ENTRY_W-1:COUNT_BITS];
        sum_add = {1'b0, rd_sum} + (SUM_W + 1)'(hgt_reg);
        new_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        if (is_add && (rd_cnt != '1))
        begin
            upd_entry = {new_sum, rd_cnt + COUNT_BITS'(1)};
        end
        else
        begin
            upd_entry = ram_rdata;
        end
        wr_cnt = ram_wdata[COUNT_BITS-1:0];

        ent_cnt  = entry_reg[COUNT_BITS-1:0];
        ent_sum  = entry_reg[ENTRY_W-1:COUNT_BITS];
        cnt_zero = (ent_cnt == '0);
        grey_sat = (CMP_W'(num_reg) >= CMP_W'({prod_reg, {GREY_W{1'b0}}}));
    end

    assign accept    = item_valid && !item_stall;
    assign slot_free = !out_valid_reg || !result_stall;
    assign clr_last  = (clr_reg == LAST_CELL);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.mode)
                        MODE_ADD:   state_next = S_XGO;
                        MODE_READ:  state_next = S_QCHK;
                        MODE_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_XGO:   state_next = S_XWAIT;
            S_XWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_YWAIT;
                end
            end
            S_YWAIT:
            begin
                if (div_done)
                begin
                    state_next = (row_ok && col_ok_reg) ? S_READ : S_DONE;
                end
            end
            S_QCHK:   state_next = query_ok ? S_READ : S_DONE;
            S_READ:   state_next = S_MODIFY;
            S_MODIFY: state_next = S_SCALE;
            S_SCALE:  state_next = S_GREY;
            S_GREY:   state_next = (cnt_zero || grey_sat) ? S_DONE : S_GWAIT;
            S_GWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        item_stall = (state_reg != S_IDLE);

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = upd_entry;
        clr_next  = clr_reg;

        div_cmd.start = 1'b0;
        div_cmd.steps = COORD_STEPS;
        div_rem       = '0;
        div_num       = dx[QUO_W-1:0];
        div_den       = DEN_W'(edge_eff);

        out_valid_next = out_valid_reg && result_stall;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_last ? '0 : clr_reg + CELL_AW'(1);
            end
            S_XGO:
            begin
                div_cmd.start = 1'b1;
            end
            S_XWAIT:
            begin
                div_cmd.start = div_done;
                div_num       = dy[QUO_W-1:0];
            end
            S_MODIFY:
            begin
                ram_we = is_add;
            end
            S_GREY:
            begin
                // quotient is known to fit in 8 bits here; seed the remainder with the top bits
                div_cmd.start = !(cnt_zero || grey_sat);
                div_cmd.steps = GREY_STEPS;
                div_rem       = DEN_W'(num_reg >> GREY_W);
                div_num       = {num_reg[GREY_W-1:0], {PAD_W{1'b0}}};
                div_den       = prod_reg;
            end
            S_DONE:
            begin
                out_valid_next = out_valid_reg && result_stall || slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        hgt_reg <= hgt;

        if (accept)
        begin
            item_reg  <= item;
            row_reg   <= '0;
            col_reg   <= '0;
            ing_reg   <= 1'b0;
            grey_reg  <= '0;
            entry_reg <= '0;
        end

        case (state_reg)
            S_XWAIT:
            begin
                if (div_done)
                begin
                    col_q_reg  <= div_quo;
                    col_ok_reg <= col_ok;
                end
            end
            S_YWAIT:
            begin
                if (div_done && row_ok && col_ok_reg)
                begin
                    row_reg  <= div_quo;
                    col_reg  <= col_q_reg;
                    ing_reg  <= 1'b1;
                    addr_reg <= CELL_AW'(div_quo * QUO_W'(GRID_COLS) + col_q_reg);
                end
            end
            S_QCHK:
            begin
                row_reg  <= q_row;
                col_reg  <= q_col;
                ing_reg  <= query_ok;
                addr_reg <= CELL_AW'(q_row * QUO_W'(GRID_COLS) + q_col);
            end
            S_MODIFY:
            begin
                entry_reg <= upd_entry;
            end
            S_SCALE:
            begin
                prod_reg <= DEN_W'(ent_cnt) * DEN_W'(span_eff);
                num_reg  <= {ent_sum, {GREY_W{1'b0}}} - NUM_W'(ent_sum);
            end
            S_GREY:
            begin
                if (cnt_zero)
                begin
                    grey_reg <= '0;
                end
                else if (grey_sat)
                begin
                    grey_reg <= GREY_MAX;
                end
            end
            S_GWAIT:
            begin
                if (div_done)
                begin
                    grey_reg <= div_quo[GREY_W-1:0];
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_reg.cell_row    <= row_reg[CELL_IDX_W-1:0];
                    out_reg.cell_col    <= col_reg[CELL_IDX_W-1:0];
                    out_reg.in_grid     <= ing_reg;
                    out_reg.grey_level  <= grey_reg;
                    out_reg.point_count <= OUT_CNT_W'(ent_cnt);
                end
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_MODIFY) |-> (wr_cnt == rd_cnt) || (wr_cnt == rd_cnt + 1'b1))
        else $error("cell count changed by more than one");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_XWAIT) || (state_reg == S_YWAIT) || (state_reg == S_GWAIT))
        else $error("divider finished with no consumer");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");

    a_grey_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.grey_level != '0) |-> result.in_grid)
        else $error("nonzero grey level for a cell outside the grid");

endmodule

`default_nettype wire

@@ hw/rtl/pchg_ram.sv @@
`default_nettype none

module pchg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              clk,
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [WIDTH-1:0] wr_data,
    input  wire  [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pchg_div.sv @@
`default_nettype none

module pchg_div
    import pchg_pkg::*;
#(
    parameter int DEN_W = 40
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire  div_cmd_t   cmd,
    input  wire  [DEN_W-1:0] rem_init,
    input  wire  [QUO_W-1:0] num,
    input  wire  [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  num_reg, num_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, num_reg[QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            rem_next  = rem_init;
            den_next  = den;
            num_next  = num;
            quo_next  = '0;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = {num_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pchg_cfg.sv @@
`default_nettype none

module pchg_cfg
    import pchg_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_strobe;

    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_strobe)
        begin
            case (reg_idx)
                REG_ORIGIN_X:    cfg_next.origin_x    = pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:    cfg_next.origin_y    = pwdata[COORD_W-1:0];
                REG_FLOOR_Z:     cfg_next.floor_z     = pwdata[COORD_W-1:0];
                REG_HEIGHT_SPAN: cfg_next.height_span = pwdata[COORD_W-1:0];
                REG_CELL_EDGE:   cfg_next.cell_edge   = pwdata[EDGE_W-1:0];
                REG_ROWS_IN_USE: cfg_next.rows_in_use = pwdata[USE_W-1:0];
                REG_COLS_IN_USE: cfg_next.cols_in_use = pwdata[USE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:    prdata = APB_DATA_W'(cfg_reg.origin_x);
            REG_ORIGIN_Y:    prdata = APB_DATA_W'(cfg_reg.origin_y);
            REG_FLOOR_Z:     prdata = APB_DATA_W'(cfg_reg.floor_z);
            REG_HEIGHT_SPAN: prdata = APB_DATA_W'(cfg_reg.height_span);
            REG_CELL_EDGE:   prdata = APB_DATA_W'(cfg_reg.cell_edge);
            REG_ROWS_IN_USE: prdata = APB_DATA_W'(cfg_reg.rows_in_use);
            REG_COLS_IN_USE: prdata = APB_DATA_W'(cfg_reg.cols_in_use);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pchg_pkg::*;

    localparam int GRID_ROWS   = 256;
    localparam int GRID_COLS   = 256;
    localparam int COUNT_BITS  = 16;
    localparam int CELLS       = GRID_ROWS * GRID_COLS;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int CYCLE_LIMIT = 3_000_000;

    localparam longint unsigned SUM_CAP   = (64'd1 << 40) - 64'd1;
    localparam longint unsigned TALLY_CAP = (64'd1 << COUNT_BITS) - 64'd1;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        bit                     is_cfg;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [31:0]            value;
        item_t                  it;
        bit                     typed;
        result_t                want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // grid model: configuration and per-cell state
    cfg_t            grid_cfg = CFG_RESET;
    longint unsigned height_sum [CELLS];
    int unsigned     point_tally [CELLS];

    result_t   expected_cells [$];
    stim_row_t directed_rows [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        cycle_count  = 0;
    int        quiet_items  = 0;
    bit        calm         = 1'b0;

    point_cloud_height_grid_top #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_cells.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void append_row(stim_row_t s);
        directed_rows.insert(directed_rows.size(), s);
    endfunction

    function automatic void expect_result(result_t r);
        expected_cells.insert(expected_cells.size(), r);
    endfunction

    function automatic longint sx24(logic [23:0] v);
        return {{40{v[23]}}, v};
    endfunction

    function automatic longint rows_lim();
        return (grid_cfg.rows_in_use > GRID_ROWS) ? GRID_ROWS : longint'(grid_cfg.rows_in_use);
    endfunction

    function automatic longint cols_lim();
        return (grid_cfg.cols_in_use > GRID_COLS) ? GRID_COLS : longint'(grid_cfg.cols_in_use);
    endfunction

    function automatic longint edge_eff();
        return (grid_cfg.cell_edge == 0) ? 1 : longint'(grid_cfg.cell_edge);
    endfunction

    function automatic longint span_eff();
        return (grid_cfg.height_span == 0) ? 1 : longint'(grid_cfg.height_span);
    endfunction

    // floor index of a coordinate, -1 when left of the origin or past the limit
    function automatic longint cell_bin(logic [23:0] p, logic [23:0] org, longint limit);
        longint d;
        longint q;
        d = sx24(p) - sx24(org);
        if (d < 0)
            return -1;
        q = d / edge_eff();
        return (q < limit) ? q : -1;
    endfunction

    function automatic logic [7:0] cell_grey(int idx);
        longint unsigned g;
        if (point_tally[idx] == 0)
            return 8'd0;
        g = (height_sum[idx] * 255) / (longint'(point_tally[idx]) * span_eff());
        return (g > 255) ? 8'd255 : g[7:0];
    endfunction

    // apply one transaction to the grid model and return the result it should produce
    function automatic result_t grid_op(item_t it);
        result_t         r;
        longint          row;
        longint          col;
        longint          h;
        longint unsigned s;
        int              idx;
        r = '0;
        case (it.mode)
            MODE_ADD:
            begin
                row = cell_bin(it.point_y, grid_cfg.origin_y, rows_lim());
                col = cell_bin(it.point_x, grid_cfg.origin_x, cols_lim());
                if (row >= 0 && col >= 0)
                begin
                    idx = int'(row * GRID_COLS + col);
                    h = sx24(it.point_z) - sx24(grid_cfg.floor_z);
                    if (h < 0)
                        h = 0;
                    if (h > span_eff())
                        h = span_eff();
                    if (point_tally[idx] < TALLY_CAP)
                    begin
                        s = height_sum[idx] + longint'(h);
                        point_tally[idx]++;
                        height_sum[idx] = (s > SUM_CAP) ? SUM_CAP : s;
                    end
                    r.cell_row    = row[7:0];
                    r.cell_col    = col[7:0];
                    r.in_grid     = 1'b1;
                    r.grey_level  = cell_grey(idx);
                    r.point_count = point_tally[idx][15:0];
                end
            end
            MODE_READ:
            begin
                r.cell_row = it.query_row;
                r.cell_col = it.query_col;
                if (it.query_row < rows_lim() && it.query_col < cols_lim())
                begin
                    idx = int'(it.query_row) * GRID_COLS + int'(it.query_col);
                    r.in_grid     = 1'b1;
                    r.grey_level  = cell_grey(idx);
                    r.point_count = point_tally[idx][15:0];
                end
            end
            MODE_CLEAR:
            begin
                foreach (height_sum[i])
                begin
                    height_sum[i]  = 0;
                    point_tally[i] = 0;
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic item_t add_pt(int x, int y, int z);
        item_t it;
        it = '0;
        it.mode    = MODE_ADD;
        it.point_x = x[23:0];
        it.point_y = y[23:0];
        it.point_z = z[23:0];
        return it;
    endfunction

    function automatic item_t read_at(int r, int c);
        item_t it;
        it = '0;
        it.mode      = MODE_READ;
        it.query_row = r[7:0];
        it.query_col = c[7:0];
        return it;
    endfunction

    function automatic result_t cell_result(int r, int c, bit in_g, int g, int n);
        result_t res;
        res.cell_row    = r[7:0];
        res.cell_col    = c[7:0];
        res.in_grid     = in_g;
        res.grey_level  = g[7:0];
        res.point_count = n[15:0];
        return res;
    endfunction

    function automatic stim_row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        stim_row_t s;
        s = '{default: 0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.value   = value;
        return s;
    endfunction

    function automatic stim_row_t item_row(item_t it, bit typed, result_t want);
        stim_row_t s;
        s = '{default: 0};
        s.it    = it;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // add point with random content, aimed at the area the grid covers
    function automatic item_t near_grid_point(item_t it);
        longint reach_x;
        longint reach_y;
        longint reach_z;
        longint v;
        reach_x = cols_lim() * edge_eff();
        reach_x = reach_x + reach_x / 8 + 2;
        if (reach_x > 64'd16777215)
            reach_x = 64'd16777215;
        reach_y = rows_lim() * edge_eff();
        reach_y = reach_y + reach_y / 8 + 2;
        if (reach_y > 64'd16777215)
            reach_y = 64'd16777215;
        reach_z = span_eff() + span_eff() / 4 + 2;
        if (reach_z > 64'd16777215)
            reach_z = 64'd16777215;
        it.mode = MODE_ADD;
        v = sx24(grid_cfg.origin_x) + longint'($urandom_range(32'(reach_x), 0)) - 2;
        it.point_x = v[23:0];
        v = sx24(grid_cfg.origin_y) + longint'($urandom_range(32'(reach_y), 0)) - 2;
        it.point_y = v[23:0];
        v = sx24(grid_cfg.floor_z) + longint'($urandom_range(32'(reach_z), 0))
            - span_eff() / 8 - 1;
        it.point_z = v[23:0];
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < 50)
            $display("MISMATCH cycle %0d result %0d: %s", cycle_count, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_cells.size() == 0)
                report_mismatch($sformatf("unexpected transaction %h", result));
            else
            begin
                want = expected_cells.pop_front();
                check_field("cell_row", result.cell_row, want.cell_row);
                check_field("cell_col", result.cell_col, want.cell_col);
                check_field("in_grid", result.in_grid, want.in_grid);
                check_field("grey_level", result.grey_level, want.grey_level);
                check_field("point_count", result.point_count, want.point_count);
            end
            results_seen++;
        end
    end

    // result side back-pressure: bursts of stall between free stretches
    initial
    begin
        int run;
        run = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                result_stall = 1'b0;
                run = 0;
            end
            else
            begin
                if (run == 0)
                begin
                    if ($urandom_range(2, 0) == 0)
                    begin
                        result_stall = 1'b1;
                        run = $urandom_range(14, 1);
                    end
                    else
                    begin
                        result_stall = 1'b0;
                        run = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 40)
                                                           : $urandom_range(20, 1);
                    end
                end
                run--;
            end
        end
    end

    // called and returns just after a falling edge
    task automatic send_item(item_t it, bit typed, result_t want);
        result_t guess;
        int      gap;
        guess = grid_op(it);
        expect_result(typed ? want : guess);
        gap = 0;
        if (!calm)
        begin
            if (quiet_items > 0)
                quiet_items--;
            else
            begin
                if ($urandom_range(2, 0) == 0)
                    gap = $urandom_range(14, 1);
                if ($urandom_range(15, 0) == 0)
                    quiet_items = $urandom_range(40, 10);
            end
        end
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_valid = 1'b0;
        while (expected_cells.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] junk;
        case (idx)
            REG_CELL_EDGE:                    mask = 32'h0000_FFFF;
            REG_ROWS_IN_USE, REG_COLS_IN_USE: mask = 32'h0000_01FF;
            default:                          mask = 32'h00FF_FFFF;
        endcase
        // unused upper bits must be ignored
        junk    = ($urandom_range(3, 0) == 0) ? $urandom : 32'd0;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = (value & mask) | (junk & ~mask);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ORIGIN_X:    grid_cfg.origin_x    = value[23:0];
            REG_ORIGIN_Y:    grid_cfg.origin_y    = value[23:0];
            REG_FLOOR_Z:     grid_cfg.floor_z     = value[23:0];
            REG_HEIGHT_SPAN: grid_cfg.height_span = value[23:0];
            REG_CELL_EDGE:   grid_cfg.cell_edge   = value[15:0];
            REG_ROWS_IN_USE: grid_cfg.rows_in_use = value[8:0];
            REG_COLS_IN_USE: grid_cfg.cols_in_use = value[8:0];
            default:         ;
        endcase
    endtask

    task automatic program_phase(int flavor);
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] fz;
        int          rows;
        int          cols;
        int          edge_mm;
        int          span;
        ox = $urandom_range(32'h7F_FFFF, 0) - 32'h40_0000;
        oy = $urandom_range(32'h7F_FFFF, 0) - 32'h40_0000;
        fz = $urandom_range(32'h7F_FFFF, 0) - 32'h40_0000;
        case (flavor)
            1:
            begin
                case ($urandom_range(2, 0))
                    0:       rows = 256;
                    1:       rows = 511;
                    default: rows = 300;
                endcase
                cols    = ($urandom_range(1, 0) == 0) ? 256 : 511;
                edge_mm = $urandom_range(3, 1);
                span    = 16777215;
            end
            2:
            begin
                ox      = 32'hFF80_0000;
                oy      = 32'hFF80_0000;
                rows    = $urandom_range(256, 1);
                cols    = $urandom_range(256, 1);
                edge_mm = 65535;
                span    = 1;
            end
            3:
            begin
                rows    = 1;
                cols    = $urandom_range(256, 1);
                edge_mm = 0;
                span    = 0;
            end
            4:
            begin
                rows    = $urandom_range(511, 1);
                cols    = $urandom_range(511, 1);
                edge_mm = $urandom_range(65535, 1);
                span    = $urandom_range(16777215, 1);
            end
            default:
            begin
                rows    = $urandom_range(6, 1);
                cols    = $urandom_range(6, 1);
                edge_mm = $urandom_range(60, 1);
                span    = $urandom_range(3000, 1);
            end
        endcase
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_FLOOR_Z, fz);
        write_reg(REG_HEIGHT_SPAN, span);
        write_reg(REG_CELL_EDGE, edge_mm);
        write_reg(REG_ROWS_IN_USE, rows);
        write_reg(REG_COLS_IN_USE, cols);
    endtask

    initial
    begin
        item_t        it;
        logic [127:0] raw;
        int           pick;
        int           clears_left;
        longint       row_top;
        longint       col_top;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        clears_left = 2;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.mode = MODE_UNUSED;

        append_row(item_row(read_at(0, 0), 1, cell_result(0, 0, 1, 0, 0)));
        append_row(item_row(read_at(255, 255), 1, cell_result(255, 255, 1, 0, 0)));
        append_row(item_row(add_pt(0, 0, 1000), 1, cell_result(0, 0, 1, 255, 1)));
        append_row(item_row(add_pt(49, 49, 0), 1, cell_result(0, 0, 1, 127, 2)));
        append_row(item_row(add_pt(50, 0, 500), 1, cell_result(0, 1, 1, 127, 1)));
        append_row(item_row(add_pt(-1, 0, 0), 1, '0));
        append_row(item_row(add_pt(0, -8388608, 0), 1, '0));
        append_row(item_row(add_pt(8388607, 0, 0), 1, '0));
        append_row(item_row(add_pt(12799, 12799, -8388608), 1,
                            cell_result(255, 255, 1, 0, 1)));
        append_row(item_row(add_pt(12800, 0, 0), 1, '0));
        append_row(item_row(add_pt(100, 100, 8388607), 1, cell_result(2, 2, 1, 255, 1)));
        append_row(item_row(it, 1, '0));
        append_row(item_row(read_at(2, 2), 1, cell_result(2, 2, 1, 255, 1)));
        it = '0;
        it.mode = MODE_CLEAR;
        append_row(item_row(it, 1, '0));
        append_row(item_row(read_at(0, 0), 1, cell_result(0, 0, 1, 0, 0)));
        append_row(cfg_row(REG_ROWS_IN_USE, 0));
        append_row(item_row(read_at(3, 4), 1, cell_result(3, 4, 0, 0, 0)));
        append_row(item_row(add_pt(0, 0, 0), 1, '0));
        append_row(cfg_row(REG_ROWS_IN_USE, 511));
        append_row(cfg_row(REG_COLS_IN_USE, 300));
        append_row(item_row(read_at(255, 255), 1, cell_result(255, 255, 1, 0, 0)));
        append_row(cfg_row(REG_CELL_EDGE, 0));
        append_row(cfg_row(REG_HEIGHT_SPAN, 0));
        append_row(cfg_row(REG_ORIGIN_X, 32'hFF80_0000));
        append_row(cfg_row(REG_ORIGIN_Y, 32'h007F_FFFF));
        append_row(cfg_row(REG_FLOOR_Z, 32'h007F_FFFF));
        append_row(item_row(add_pt(-8388603, 8388607, 8388607), 0, '0));
        append_row(item_row(add_pt(-8388603, 8388607, -8388608), 0, '0));
        append_row(item_row(add_pt(-8388308, 8388607, 0), 0, '0));
        append_row(cfg_row(REG_CELL_EDGE, 65535));
        append_row(cfg_row(REG_HEIGHT_SPAN, 16777215));
        append_row(cfg_row(REG_ORIGIN_X, 0));
        append_row(cfg_row(REG_ORIGIN_Y, 32'hFF80_0000));
        append_row(cfg_row(REG_FLOOR_Z, 32'hFF80_0000));
        append_row(cfg_row(REG_ROWS_IN_USE, 256));
        append_row(cfg_row(REG_COLS_IN_USE, 1));
        append_row(item_row(add_pt(65534, 8388607, 8388607), 0, '0));
        append_row(item_row(add_pt(65535, 0, 8388607), 0, '0));
        append_row(item_row(add_pt(0, 0, 8388607), 0, '0));
        append_row(item_row(read_at(128, 0), 0, '0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
                send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            program_phase(p);
            // last phase runs with no idling on either side
            if (p == PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99, 0);
                raw = {$urandom, $urandom, $urandom, $urandom};
                it = raw[$bits(item_t)-1:0];
                if (pick < 4)
                begin
                    if (it.mode == MODE_CLEAR)
                        it.mode = MODE_UNUSED;
                end
                else if (pick < 6)
                    it.mode = MODE_UNUSED;
                else if (pick < 70)
                    it = near_grid_point(it);
                else if (pick == 99 && clears_left > 0 && $urandom_range(2, 0) == 0)
                begin
                    it.mode = MODE_CLEAR;
                    clears_left--;
                end
                else
                begin
                    row_top = (rows_lim() + 1 > 255) ? 255 : rows_lim() + 1;
                    col_top = (cols_lim() + 1 > 255) ? 255 : cols_lim() + 1;
                    it.mode      = MODE_READ;
                    it.query_row = 8'($urandom_range(32'(row_top), 0));
                    it.query_col = 8'($urandom_range(32'(col_top), 0));
                end
                send_item(it, 0, '0);
            end
        end
        item_valid = 1'b0;

        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
